// File: rtl/dbw_pkg.sv
// Shared constants and types for the immersed-boundary delta weight unit.
// No dependencies; compile first.
package dbw_pkg;

   // Field widths of the channels
   localparam int COORD_W   = 32;
   localparam int WEIGHT_W  = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   // Configuration register map; the spare index holds no register
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INV_X = 2'd0,
      CSR_INV_Y = 2'd1,
      CSR_INV_Z = 2'd2,
      CSR_SPARE = 2'd3
   } csr_idx_type;

endpackage

// File: rtl/dbw_req_if.sv
// Channel interfaces: request (point pair), response (weight) and register write.
// Depends on dbw_pkg for field widths.
interface dbw_req_if import dbw_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] cloud_x;
   logic signed [COORD_W-1:0] cloud_y;
   logic signed [COORD_W-1:0] cloud_z;
   logic signed [COORD_W-1:0] grid_x;
   logic signed [COORD_W-1:0] grid_y;
   logic signed [COORD_W-1:0] grid_z;

   modport source (output valid, cloud_x, cloud_y, cloud_z, grid_x, grid_y, grid_z,
                   input ready);
   modport sink   (input valid, cloud_x, cloud_y, cloud_z, grid_x, grid_y, grid_z,
                   output ready);
endinterface

interface dbw_rsp_if import dbw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [WEIGHT_W-1:0] weight_value;
   logic                in_support;
   logic                saturated;

   modport source (output valid, weight_value, in_support, saturated, input ready);
   modport sink   (input valid, weight_value, in_support, saturated, output ready);
endinterface

interface dbw_csr_if import dbw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/dbw_axis.sv
// One axis of the delta weight: scaled distance, four-point kernel with a
// pipelined digit-by-digit square root, and kernel times inverse spacing.
// Self-contained; every stage advances on en.
module dbw_axis #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        en,
   input  logic [32:0] dist_in,
   input  logic [31:0] inv_spacing,
   output logic [31:0] scaled_phi,
   output logic        beyond
);

   localparam int SW  = FRAC_BITS + 1;      // root bits
   localparam int AW  = 2 * SW;             // radicand bits
   localparam int RW  = SW + 2;             // remainder bits
   localparam int RQW = 65 - FRAC_BITS;     // full scaled distance
   localparam int CW  = FRAC_BITS + 2;      // clamped distance, up to 2.0
   localparam int XW  = 2 * FRAC_BITS + 6;  // radicand working width
   localparam int NW  = FRAC_BITS + 3;      // kernel numerator

   localparam logic [RQW-1:0] ONE_RQ  = RQW'(1) << FRAC_BITS;
   localparam logic [RQW-1:0] TWO_RQ  = RQW'(2) << FRAC_BITS;
   localparam logic [XW-1:0]  ONE2_X  = XW'(1) << (2 * FRAC_BITS);
   localparam logic [XW-1:0]  SEVEN2_X = XW'(7) << (2 * FRAC_BITS);
   localparam logic [NW-1:0]  THREE_N = NW'(3) << FRAC_BITS;
   localparam logic [NW-1:0]  FIVE_N  = NW'(5) << FRAC_BITS;

   // Stage 1: distance times inverse spacing, split into 32x32 plus a top-bit term
   logic [63:0] prod_lo;
   logic [64:0] prod_in, prod_ff;

   always_comb begin
      prod_lo = 64'(dist_in[31:0]) * 64'(inv_spacing);
      prod_in = {1'b0, prod_lo} + (dist_in[32] ? {1'b0, inv_spacing, 32'd0} : 65'd0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   // Stage 2: classify and clamp the scaled distance
   logic [RQW-1:0] rq;
   logic [CW-1:0]  rc_ff;
   logic           le1_ff, over_ff;

   assign rq = prod_ff[64:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (en) begin
         over_ff <= (rq > TWO_RQ);
         le1_ff  <= (rq <= ONE_RQ);
         rc_ff   <= (rq > TWO_RQ) ? '0 : rq[CW-1:0];
      end
   end

   // Stage 3: square of the distance
   logic [2*CW-1:0] rsq_ff;
   logic [CW-1:0]   rc3_ff;
   logic            le13_ff, over3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rsq_ff   <= (2*CW)'(rc_ff) * (2*CW)'(rc_ff);
         rc3_ff   <= rc_ff;
         le13_ff  <= le1_ff;
         over3_ff <= over_ff;
      end
   end

   // Stage 4: radicand for the inner or outer branch, clipped at zero
   logic [XW-1:0] r_x, sq4, arg_near, pos_x, neg_x, arg_far;
   logic [AW-1:0] arg_ff;
   logic [CW-1:0] rc4_ff;
   logic          le14_ff, over4_ff;

   always_comb begin
      r_x      = XW'(rc3_ff);
      sq4      = XW'(rsq_ff) << 2;
      arg_near = ONE2_X + (r_x << (FRAC_BITS + 2)) - sq4;
      pos_x    = (r_x << (FRAC_BITS + 3)) + (r_x << (FRAC_BITS + 2));
      neg_x    = sq4 + SEVEN2_X;
      arg_far  = (pos_x > neg_x) ? (pos_x - neg_x) : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         arg_ff   <= le13_ff ? arg_near[AW-1:0] : arg_far[AW-1:0];
         rc4_ff   <= rc3_ff;
         le14_ff  <= le13_ff;
         over4_ff <= over3_ff;
      end
   end

   // Square root: one result bit per stage
   logic [RW-1:0] rem_ff  [SW];
   logic [SW-1:0] root_ff [SW];
   logic [AW-1:0] sarg_ff [SW];
   logic [CW-1:0] src_ff  [SW];
   logic          sle1_ff [SW];
   logic          sover_ff[SW];

   for (genvar j = 0; j < SW; j++) begin : g_sqrt
      logic [RW-1:0] rem_src, rem_sh, trial;
      logic [SW-1:0] root_src;
      logic [AW-1:0] arg_src;
      logic [CW-1:0] rc_src;
      logic          le1_src, over_src, fits;

      if (j == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign arg_src  = arg_ff;
         assign rc_src   = rc4_ff;
         assign le1_src  = le14_ff;
         assign over_src = over4_ff;
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign root_src = root_ff[j-1];
         assign arg_src  = sarg_ff[j-1];
         assign rc_src   = src_ff[j-1];
         assign le1_src  = sle1_ff[j-1];
         assign over_src = sover_ff[j-1];
      end

      always_comb begin
         rem_sh = {rem_src[RW-3:0], arg_src[AW-1-2*j -: 2]};
         trial  = {root_src, 2'b01};
         fits   = (rem_sh >= trial);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]   <= fits ? (rem_sh - trial) : rem_sh;
            root_ff[j]  <= {root_src[SW-2:0], fits};
            sarg_ff[j]  <= arg_src;
            src_ff[j]   <= rc_src;
            sle1_ff[j]  <= le1_src;
            sover_ff[j] <= over_src;
         end
      end
   end

   // Kernel value from distance and root
   logic [NW-1:0]        s_n, r2_n, num_near, num_far, num;
   logic [FRAC_BITS-1:0] phi_ff;
   logic                 over5_ff;

   always_comb begin
      s_n      = NW'(root_ff[SW-1]);
      r2_n     = NW'(src_ff[SW-1]) << 1;
      num_near = THREE_N - r2_n + s_n;
      num_far  = (FIVE_N - r2_n > s_n) ? (FIVE_N - r2_n - s_n) : '0;
      num      = sle1_ff[SW-1] ? num_near : num_far;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phi_ff   <= sover_ff[SW-1] ? '0 : num[NW-1:3];
         over5_ff <= sover_ff[SW-1];
      end
   end

   // Kernel times inverse spacing
   logic [FRAC_BITS+31:0] aprod;
   logic [31:0]           a_ff;
   logic                  over6_ff;

   assign aprod = (FRAC_BITS+32)'(phi_ff) * (FRAC_BITS+32)'(inv_spacing);

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff     <= aprod[FRAC_BITS+31:FRAC_BITS];
         over6_ff <= over5_ff;
      end
   end

   assign scaled_phi = a_ff;
   assign beyond     = over6_ff;

endmodule

// File: rtl/immersed_boundary_delta_weight_unit.sv
// Four-point delta weight between a Lagrangian point and a grid cell centre,
// built on dbw_pkg, the channel interfaces and three dbw_axis lanes.
//
// Takes one point pair per clock while the output is not stalled, and returns
// one weight per pair, in order. The square-root pipeline in each axis lane
// resolves one root bit per stage. The whole pipeline advances whenever the
// output register is empty or being taken, so a stalled result holds every
// stage. Inverse spacings reset to 20.0; the user must write them through the
// register port only while no pair is in flight, which the block does not
// enforce. The port is always ready and ignores index 3.
module immersed_boundary_delta_weight_unit import dbw_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   dbw_req_if.sink   req_if,
   dbw_rsp_if.source rsp_if,
   dbw_csr_if.sink   csr_if
);

   localparam int SW  = FRAC_BITS + 1;
   localparam int KL  = SW + 6;          // axis lane latency
   localparam int LAT = KL + 5;          // distance, lanes, product stages, output
   localparam int PW  = 64 - FRAC_BITS;  // first product width
   localparam int PHW = PW - 32;         // upper slice of first product
   localparam int TW  = PHW + 65;        // full weight product

   // Register file
   logic [31:0] inv_ff [3];

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            inv_ff[k] <= 32'(20) << FRAC_BITS;
         end
      end else if (csr_if.valid) begin
         case (csr_idx_type'(csr_if.index))
            CSR_INV_X: inv_ff[0] <= csr_if.data;
            CSR_INV_Y: inv_ff[1] <= csr_if.data;
            CSR_INV_Z: inv_ff[2] <= csr_if.data;
            default: ;
         endcase
      end
   end

   // Flow control: advance unless the output beat is held
   logic           en;
   logic [LAT-1:0] vld_ff;

   assign en           = !vld_ff[LAT-1] || rsp_if.ready;
   assign req_if.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_if.valid};
      end
   end

   // Stage 0: absolute distances
   logic signed [32:0] diff [3];
   logic [32:0]        ad_ff [3];

   always_comb begin
      diff[0] = 33'(req_if.grid_x) - 33'(req_if.cloud_x);
      diff[1] = 33'(req_if.grid_y) - 33'(req_if.cloud_y);
      diff[2] = 33'(req_if.grid_z) - 33'(req_if.cloud_z);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            ad_ff[k] <= diff[k][32] ? 33'(-diff[k]) : 33'(diff[k]);
         end
      end
   end

   // Axis lanes
   logic [31:0] a_w [3];
   logic        far_w [3];

   for (genvar k = 0; k < 3; k++) begin : g_axis
      dbw_axis #(.FRAC_BITS(FRAC_BITS)) u_axis (
         .clock       (clock),
         .en          (en),
         .dist_in     (ad_ff[k]),
         .inv_spacing (inv_ff[k]),
         .scaled_phi  (a_w[k]),
         .beyond      (far_w[k])
      );
   end

   // Product of x and y terms
   logic [63:0]   pxy;
   logic [PW-1:0] p_ff;
   logic [31:0]   az_ff;
   logic          sup_ff;

   assign pxy = 64'(a_w[0]) * 64'(a_w[1]);

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff   <= pxy[63:FRAC_BITS];
         az_ff  <= a_w[2];
         sup_ff <= !(far_w[0] || far_w[1] || far_w[2]);
      end
   end

   // Lower partial product with z
   logic [63:0]    mlo_ff;
   logic [PHW-1:0] ph_ff;
   logic [31:0]    az2_ff;
   logic           sup2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mlo_ff  <= 64'(p_ff[31:0]) * 64'(az_ff);
         ph_ff   <= p_ff[PW-1:32];
         az2_ff  <= az_ff;
         sup2_ff <= sup_ff;
      end
   end

   // Upper partial product with z
   logic [PHW+31:0] mhi_ff;
   logic [63:0]     mlo2_ff;
   logic            sup3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mhi_ff  <= (PHW+32)'(ph_ff) * (PHW+32)'(az2_ff);
         mlo2_ff <= mlo_ff;
         sup3_ff <= sup2_ff;
      end
   end

   // Combine, scale and saturate into the output register
   logic [TW-1:0] tot, wsh;
   logic          sat;
   logic [31:0]   weight_ff;
   logic          sup_out_ff, sat_ff;

   always_comb begin
      tot = {1'b0, mhi_ff, 32'd0} + TW'(mlo2_ff);
      wsh = tot >> FRAC_BITS;
      sat = (wsh >> 32) != '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         weight_ff  <= sat ? '1 : wsh[31:0];
         sat_ff     <= sat;
         sup_out_ff <= sup3_ff;
      end
   end

   assign rsp_if.valid        = vld_ff[LAT-1];
   assign rsp_if.weight_value = weight_ff;
   assign rsp_if.in_support   = sup_out_ff;
   assign rsp_if.saturated    = sat_ff;

endmodule
